// File: rtl/ortt_pkg.sv
// Package for the outstanding request timeout table.
// Holds sizes, action and status codes and the result word type; no dependencies.
package ortt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ID_W    = 32;
    localparam int CD_W    = 16;
    localparam int ACT_W   = 2;
    localparam int ST_W    = 3;

    localparam logic [ACT_W-1:0] ACT_ISSUE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RESP  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd3;

    localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [ST_W-1:0] ST_REPLACED  = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
    localparam logic [ST_W-1:0] ST_COMPLETED = 3'd3;
    localparam logic [ST_W-1:0] ST_UNKNOWN   = 3'd4;
    localparam logic [ST_W-1:0] ST_TIMEDOUT  = 3'd5;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [ST_W-1:0] status;
        logic            lost;
        logic            last;
    } t_result;

endpackage

// File: rtl/ortt_if.sv
// Request and result channel interfaces for the timeout table.
// Depends on ortt_pkg for field widths.
interface ortt_in_if;
    import ortt_pkg::*;
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [ID_W-1:0]  msg_id;
    logic [CD_W-1:0]  tmo_steps;

    modport source (output valid, action, msg_id, tmo_steps, input ready);
    modport sink   (input valid, action, msg_id, tmo_steps, output ready);
endinterface

interface ortt_out_if;
    import ortt_pkg::*;
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] out_id;
    logic [ST_W-1:0] status;
    logic            lost;
    logic            last;

    modport source (output valid, out_id, status, lost, last, input ready);
    modport sink   (input valid, out_id, status, lost, last, output ready);
endinterface

// File: rtl/outstanding_request_timeout_table.sv
// Outstanding request table with timeout: an issue word inserts or refreshes a message id,
// a response word retires it, a tick word ages every live entry and a flush word drops all
// entries. Ids and countdowns live in two RAMs with registered read data; the per-slot
// valid bits are flip-flops cleared by reset, so no clearing pass is needed after reset.
// Every request word walks all ENTRIES slots through the RAM read port, one slot per
// cycle unless a full result side stalls the walk, then finishes in a final state that
// can also wait on the result side. Results leave through an output register, so the
// next request is taken while a result waits. Tick and flush results come out in
// ascending slot order; the last result of a word has last set. Tick and flush words that
// find nothing to report give no result at all.
// Depends on ortt_pkg, ortt_if, ortt_ram and ortt_out.
module outstanding_request_timeout_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ortt_in_if.sink     i_req,
    ortt_out_if.source  o_rsp
);
    import ortt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [1:0]         r_state, n_state;
    logic [ACT_W-1:0]   r_act, n_act;
    logic [ID_W-1:0]    r_id, n_id;
    logic [CD_W-1:0]    r_steps, n_steps;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic               r_hit, n_hit;
    logic [IDX_W-1:0]   r_hit_idx, n_hit_idx;
    logic               r_hv, n_hv;
    t_result            r_held, n_held;

    // RAM ports
    logic               id_we, cd_we;
    logic [IDX_W-1:0]   w_addr;
    logic [ID_W-1:0]    w_id;
    logic [CD_W-1:0]    w_cd;
    logic [ID_W-1:0]    rd_id;
    logic [CD_W-1:0]    rd_cd;

    // output stage
    logic               push;
    t_result            push_res;
    logic               can_push;

    // lowest free slot
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;

    // slot walk helpers
    logic               emit;
    t_result            new_res;

    ortt_ram #(.WIDTH(ID_W), .DEPTH(ENTRIES), .AW(IDX_W)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (w_addr),
        .i_wdata (w_id),
        .i_raddr (n_idx),
        .o_rdata (rd_id)
    );

    ortt_ram #(.WIDTH(CD_W), .DEPTH(ENTRIES), .AW(IDX_W)) u_cd_ram (
        .i_clk   (i_clk),
        .i_we    (cd_we),
        .i_waddr (w_addr),
        .i_wdata (w_cd),
        .i_raddr (n_idx),
        .o_rdata (rd_cd)
    );

    ortt_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_res      (push_res),
        .o_can_push (can_push),
        .o_rsp      (o_rsp)
    );

    assign i_req.ready = (r_state == S_IDLE);

    // Priority pick of the lowest free slot; valid bits do not change during an issue walk.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_id      = r_id;
        n_steps   = r_steps;
        n_idx     = r_idx;
        n_valid   = r_valid;
        n_hit     = r_hit;
        n_hit_idx = r_hit_idx;
        n_hv      = r_hv;
        n_held    = r_held;
        id_we     = 1'b0;
        cd_we     = 1'b0;
        w_addr    = r_idx;
        w_id      = r_id;
        w_cd      = r_steps;
        push      = 1'b0;
        push_res  = r_held;
        emit      = 1'b0;
        new_res   = '{id: rd_id, status: ST_TIMEDOUT, lost: 1'b0, last: 1'b0};

        case (r_state)
            S_IDLE: begin
                // keep slot 0 on the read port so the walk starts with fresh data
                n_idx = '0;
                if (i_req.valid) begin
                    n_act   = i_req.action;
                    n_id    = i_req.msg_id;
                    n_steps = i_req.tmo_steps;
                    n_hit   = 1'b0;
                    n_hv    = 1'b0;
                    n_state = S_WALK;
                end
            end

            S_WALK: begin
                // RAM data belongs to slot r_idx
                case (r_act)
                    ACT_ISSUE, ACT_RESP: begin
                        if (r_valid[r_idx] && (rd_id == r_id) && !r_hit) begin
                            n_hit     = 1'b1;
                            n_hit_idx = r_idx;
                        end
                    end
                    ACT_TICK: begin
                        if (r_valid[r_idx]) begin
                            if (rd_cd != '0) begin
                                cd_we = 1'b1;
                                w_cd  = CD_W'(rd_cd - 1'b1);
                            end else begin
                                emit = 1'b1;
                            end
                        end
                    end
                    default: begin
                        // flush: drop every live entry as lost
                        if (r_valid[r_idx]) begin
                            emit         = 1'b1;
                            new_res.lost = 1'b1;
                        end
                    end
                endcase

                // Hold one found result back so the final one can carry last.
                if (emit && r_hv && !can_push) begin
                    // stall: hold slot, re-read it next cycle
                    n_idx = r_idx;
                end else begin
                    if (emit) begin
                        push           = r_hv;
                        push_res       = r_held;
                        push_res.last  = 1'b0;
                        n_held         = new_res;
                        n_hv           = 1'b1;
                        n_valid[r_idx] = 1'b0;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_idx   = '0;
                        n_state = S_FIN;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end

            S_FIN: begin
                n_idx = '0;
                case (r_act)
                    ACT_ISSUE: begin
                        push_res = '{id: r_id, status: ST_FULL, lost: 1'b0, last: 1'b1};
                        if (r_hit) begin
                            push_res.status = ST_REPLACED;
                        end else if (free_found) begin
                            push_res.status = ST_INSERTED;
                        end
                        if (can_push) begin
                            push    = 1'b1;
                            n_state = S_IDLE;
                            if (r_hit) begin
                                cd_we  = 1'b1;
                                w_addr = r_hit_idx;
                            end else if (free_found) begin
                                id_we             = 1'b1;
                                cd_we             = 1'b1;
                                w_addr            = free_idx;
                                n_valid[free_idx] = 1'b1;
                            end
                        end
                    end
                    ACT_RESP: begin
                        push_res = '{id: r_id, status: ST_UNKNOWN, lost: 1'b0, last: 1'b1};
                        if (r_hit) begin
                            push_res.status = ST_COMPLETED;
                        end
                        if (can_push) begin
                            push    = 1'b1;
                            n_state = S_IDLE;
                            if (r_hit) begin
                                n_valid[r_hit_idx] = 1'b0;
                            end
                        end
                    end
                    default: begin
                        // tick or flush: release the held result as the final one
                        push_res.last = 1'b1;
                        if (!r_hv) begin
                            n_state = S_IDLE;
                        end else if (can_push) begin
                            push    = 1'b1;
                            n_hv    = 1'b0;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_valid <= '0;
            r_hit   <= 1'b0;
            r_hv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_valid <= n_valid;
            r_hit   <= n_hit;
            r_hv    <= n_hv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act     <= n_act;
        r_id      <= n_id;
        r_steps   <= n_steps;
        r_hit_idx <= n_hit_idx;
        r_held    <= n_held;
    end

endmodule

// File: rtl/ortt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ortt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// File: rtl/ortt_out.sv
// Output register stage for result words.
// Depends on ortt_pkg and ortt_out_if.
module ortt_out (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ortt_pkg::t_result i_res,
    output logic            o_can_push,
    ortt_out_if.source      o_rsp
);
    import ortt_pkg::*;

    logic    r_ov;
    t_result r_res;

    // free when empty or when the held word leaves this cycle
    assign o_can_push = !r_ov || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_push) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

    assign o_rsp.valid  = r_ov;
    assign o_rsp.out_id = r_res.id;
    assign o_rsp.status = r_res.status;
    assign o_rsp.lost   = r_res.lost;
    assign o_rsp.last   = r_res.last;

endmodule

// File: tb/outstanding_request_timeout_table_tb.sv
// Testbench for outstanding_request_timeout_table: request and result words, a table predictor
// and a result scoreboard. Depends on ortt_pkg, ortt_if and the RTL top level.
module outstanding_request_timeout_table_tb;
    import ortt_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000; // cycles with no word moving on either side
    localparam int LONG_STALL     = 300;  // result-side hold-off that backs the table up
    localparam int POOL_SIZE      = 24;   // more ids than slots, so the table can fill

    typedef struct {
        logic [ACT_W-1:0] action;
        logic [ID_W-1:0]  msg_id;
        logic [CD_W-1:0]  steps;
    } t_req;

    logic i_clk;
    logic i_rst_n;

    ortt_in_if  req_if ();
    ortt_out_if rsp_if ();

    outstanding_request_timeout_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Words waiting for the driver, and results the table owes us, oldest first.
    t_req    request_words[$];
    t_result expected_results[$];

    // Shadow copy of the table, updated at the moment each request word is taken.
    logic            live[ENTRIES];
    logic [ID_W-1:0] live_id[ENTRIES];
    logic [CD_W-1:0] countdown[ENTRIES];

    logic [ID_W-1:0] id_pool[POOL_SIZE];

    int  err_cnt       = 0;
    int  n_pushed      = 0;
    int  n_taken       = 0;
    int  quiet_cycles  = 0;
    int  send_idle_pct = 0;
    int  rcv_idle_pct  = 0;
    int  stall_cnt     = 0;
    bit  req_taken     = 0;
    bit  long_stall_req  = 0;
    bit  long_stall_done = 0;

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        err_cnt++;
    endtask

    function automatic t_result make_result(input logic [ID_W-1:0] id,
                                            input logic [ST_W-1:0] status,
                                            input logic lost);
        t_result r;
        r.id     = id;
        r.status = status;
        r.lost   = lost;
        r.last   = 1'b0;
        return r;
    endfunction

    // Work out what one request word does to the table and which results it owes.
    // Slots are walked in ascending order, so tick and flush results come out that way.
    task automatic predict_table(input t_req w);
        t_result owed[$];
        int      hit;
        int      free_slot;
        hit       = -1;
        free_slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (live[i] && live_id[i] == w.msg_id && hit < 0)
                hit = i;
            if (!live[i] && free_slot < 0)
                free_slot = i;
        end
        case (w.action)
            ACT_ISSUE: begin
                if (hit >= 0) begin
                    countdown[hit] = w.steps;
                    owed.insert(owed.size(), make_result(w.msg_id, ST_REPLACED, 1'b0));
                end else if (free_slot >= 0) begin
                    live[free_slot]      = 1'b1;
                    live_id[free_slot]   = w.msg_id;
                    countdown[free_slot] = w.steps;
                    owed.insert(owed.size(), make_result(w.msg_id, ST_INSERTED, 1'b0));
                end else begin
                    owed.insert(owed.size(), make_result(w.msg_id, ST_FULL, 1'b0));
                end
            end
            ACT_RESP: begin
                if (hit >= 0) begin
                    live[hit] = 1'b0;
                    owed.insert(owed.size(), make_result(w.msg_id, ST_COMPLETED, 1'b0));
                end else begin
                    owed.insert(owed.size(), make_result(w.msg_id, ST_UNKNOWN, 1'b0));
                end
            end
            ACT_TICK: begin
                // Age live entries; one already at zero expires instead.
                for (int i = 0; i < ENTRIES; i++) begin
                    if (live[i]) begin
                        if (countdown[i] != '0) begin
                            countdown[i] = countdown[i] - 1'b1;
                        end else begin
                            live[i] = 1'b0;
                            owed.insert(owed.size(),
                                        make_result(live_id[i], ST_TIMEDOUT, 1'b0));
                        end
                    end
                end
            end
            default: begin
                // Transport lost: drop every live entry and flag it.
                for (int i = 0; i < ENTRIES; i++) begin
                    if (live[i]) begin
                        live[i] = 1'b0;
                        owed.insert(owed.size(), make_result(live_id[i], ST_TIMEDOUT, 1'b1));
                    end
                end
            end
        endcase
        if (owed.size() > 0)
            owed[owed.size()-1].last = 1'b1;
        foreach (owed[k])
            expected_results.insert(expected_results.size(), owed[k]);
    endtask

    task automatic push_word(input logic [ACT_W-1:0] action, input logic [ID_W-1:0] id,
                             input logic [CD_W-1:0] steps);
        t_req w;
        w.action = action;
        w.msg_id = id;
        w.steps  = steps;
        request_words.insert(request_words.size(), w);
        n_pushed++;
    endtask

    // Mostly ids from a small pool so that issues, responses and ticks meet the same
    // entries; fresh ids now and then, and garbage in the fields that tick and flush ignore.
    task automatic push_random_word();
        int pick;
        int roll;
        logic [ID_W-1:0] id;
        logic [CD_W-1:0] steps;
        pick = $urandom_range(99);
        roll = $urandom_range(99);
        id   = (roll < 85) ? id_pool[$urandom_range(POOL_SIZE-1)] : ID_W'($urandom);
        roll = $urandom_range(99);
        if (roll < 70)
            steps = CD_W'($urandom_range(3));
        else if (roll < 85)
            steps = CD_W'($urandom_range(20, 4));
        else if (roll < 96)
            steps = CD_W'($urandom);
        else
            steps = '1;
        if (pick < 40)
            push_word(ACT_ISSUE, id, steps);
        else if (pick < 68)
            push_word(ACT_RESP, id, steps);
        else if (pick < 94)
            push_word(ACT_TICK, ID_W'($urandom), CD_W'($urandom));
        else
            push_word(ACT_FLUSH, ID_W'($urandom), CD_W'($urandom));
    endtask

    // Hold until every pushed word is taken and every owed result has come back.
    task automatic drain();
        while (n_taken != n_pushed || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Request driver: change only at the falling edge; hold a word until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (request_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                req_if.valid     <= 1'b1;
                req_if.action    <= request_words[0].action;
                req_if.msg_id    <= request_words[0].msg_id;
                req_if.tmo_steps <= request_words[0].steps;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random back-pressure, plus one long hold-off counted here.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (long_stall_req && !long_stall_done) begin
            rsp_if.ready <= 1'b0;
            stall_cnt++;
            if (stall_cnt >= LONG_STALL)
                long_stall_done = 1'b1;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Monitor and watchdog: sample both channels at the rising edge.
    always @(posedge i_clk) begin
        bit      moved;
        t_result exp_res;
        moved     = 1'b0;
        req_taken = 1'b0;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                req_taken = 1'b1;
                moved     = 1'b1;
                predict_table(request_words[0]);
                void'(request_words.pop_front());
                n_taken++;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                moved = 1'b1;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result id=%h status=%0d lost=%b last=%b",
                                    rsp_if.out_id, rsp_if.status, rsp_if.lost, rsp_if.last));
                end else begin
                    exp_res = expected_results.pop_front();
                    if (rsp_if.out_id !== exp_res.id)
                        report_mismatch($sformatf("out_id got %h want %h",
                                        rsp_if.out_id, exp_res.id));
                    if (rsp_if.status !== exp_res.status)
                        report_mismatch($sformatf("status got %0d want %0d (id %h)",
                                        rsp_if.status, exp_res.status, exp_res.id));
                    if (rsp_if.lost !== exp_res.lost)
                        report_mismatch($sformatf("lost got %b want %b (id %h)",
                                        rsp_if.lost, exp_res.lost, exp_res.id));
                    if (rsp_if.last !== exp_res.last)
                        report_mismatch($sformatf("last got %b want %b (id %h)",
                                        rsp_if.last, exp_res.last, exp_res.id));
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("outstanding_request_timeout_table_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.action    = ACT_ISSUE;
        req_if.msg_id    = '0;
        req_if.tmo_steps = '0;
        rsp_if.ready     = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            live[i]      = 1'b0;
            live_id[i]   = '0;
            countdown[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            id_pool[i] = ID_W'($urandom);
        id_pool[0] = '0;
        id_pool[1] = '1;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words: an empty table, id and countdown extremes, replace, unknown id,
        // a tick that only ages, a full table, expiry of several entries, then a flush.
        push_word(ACT_TICK, '1, '1);
        push_word(ACT_FLUSH, '0, '0);
        push_word(ACT_ISSUE, '0, '0);
        push_word(ACT_ISSUE, '1, '1);
        push_word(ACT_ISSUE, '0, CD_W'(1));
        push_word(ACT_RESP, 32'h1234_5678, '0);
        push_word(ACT_RESP, '1, '1);
        push_word(ACT_TICK, '0, '0);
        for (int i = 1; i < ENTRIES; i++)
            push_word(ACT_ISSUE, 32'hA5A5_0000 | ID_W'(i), (i % 2 == 0) ? CD_W'(0) : CD_W'(3));
        push_word(ACT_ISSUE, 32'h5A5A_FFFF, CD_W'(7));
        push_word(ACT_TICK, '0, '0);
        push_word(ACT_FLUSH, '1, '1);
        drain();

        // Idle-heavy receiver, lighter sender.
        send_idle_pct = 34;
        rcv_idle_pct  = 75;
        repeat (80) push_random_word();
        drain();

        // Swap the idling around.
        send_idle_pct = 75;
        rcv_idle_pct  = 34;
        repeat (80) push_random_word();
        drain();

        // No idling; hold the result side off for a long stretch while words keep coming,
        // so the table backs up and stalls its input.
        send_idle_pct  = 0;
        rcv_idle_pct   = 0;
        long_stall_req = 1'b1;
        repeat (90) push_random_word();
        drain();

        // Leave room for any stray result after the last one owed.
        repeat (ENTRIES + 4) @(posedge i_clk);
        if (err_cnt == 0)
            $display("outstanding_request_timeout_table_tb: PASS");
        else
            $display("outstanding_request_timeout_table_tb: FAIL");
        $finish;
    end

endmodule

// File: outstanding_request_timeout_table.f
rtl/ortt_pkg.sv
rtl/ortt_if.sv
rtl/ortt_ram.sv
rtl/ortt_out.sv
rtl/outstanding_request_timeout_table.sv
tb/outstanding_request_timeout_table_tb.sv
